### hdl/trge_pkg.sv
// Shared types and constants of the touchpad report gesture engine.
// Used by every module of the block but trge_ram; depends on nothing.
package trge_pkg;

  localparam int STORE_BYTES = 32;
  localparam int EDGE_DEPTH  = 8;
  localparam int SA_W        = $clog2(STORE_BYTES);
  localparam int EQ_W        = $clog2(EDGE_DEPTH);

  // Width of the shared adder, wide enough for 32-bit tick differences.
  localparam int ALU_W = 34;

  // Magnitude width of the scroll divider: centroid travel plus remainder.
  localparam int MAG_W = 17;

  // Report layout.
  localparam int PREC_LEN       = 32;
  localparam int WIDX_W         = $clog2(PREC_LEN);
  localparam int OFS_LEN_LO     = 0;
  localparam int OFS_LEN_HI     = 1;
  localparam int OFS_RID        = 2;
  localparam int OFS_BUTTONS    = 3;
  localparam int OFS_DX         = 4;
  localparam int OFS_DY         = 5;
  localparam int OFS_COUNT      = 30;
  localparam int OFS_CLICK      = 31;
  localparam int CONTACT_BASE   = 3;
  localparam int CONTACT_STRIDE = 5;
  localparam int NUM_CONTACTS   = 5;
  localparam int CONTACT_END    = CONTACT_BASE + CONTACT_STRIDE * NUM_CONTACTS - 1;

  localparam logic [7:0]  RID_MOUSE     = 8'd2;
  localparam logic [7:0]  RID_PREC      = 8'd3;
  localparam logic [15:0] HDR_MIN_LEN   = 16'd3;
  localparam logic [15:0] MOUSE_MIN_LEN = 16'd6;
  localparam logic [15:0] PREC_MIN_LEN  = 16'd32;
  localparam logic [6:0]  MAX_CONTACTS  = 7'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SCROLL_STEP = 2'd0;
  localparam logic [1:0] CFG_TAP_TIME    = 2'd1;
  localparam logic [1:0] CFG_TAP_TRAVEL  = 2'd2;

  // Fields captured while the stored report is walked.
  typedef struct packed {
    logic [15:0] len;
    logic [7:0]  rid;
    logic [7:0]  buttons;
    logic [7:0]  dx;
    logic [7:0]  dy;
    logic [7:0]  count;
    logic [7:0]  click;
    logic [1:0]  active;
    logic [2:0]  id0;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
  } fields_t;

endpackage

### hdl/trge_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module trge_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/trge_alu.sv
// Shared add/subtract unit with signed and unsigned 16-bit clamps.
// Depends on trge_pkg.
module trge_alu
  import trge_pkg::*;
(
  input  logic signed [ALU_W-1:0] a_i,
  input  logic signed [ALU_W-1:0] b_i,
  input  logic                    sub_i,
  output logic signed [ALU_W-1:0] res_o,
  output logic        [15:0]      sat_s_o,
  output logic        [15:0]      sat_u_o
);

  always_comb begin
    res_o = sub_i ? (a_i - b_i) : (a_i + b_i);
    if (res_o > ALU_W'(32767)) begin
      sat_s_o = 16'h7fff;
    end else if (res_o < -ALU_W'(32768)) begin
      sat_s_o = 16'h8000;
    end else begin
      sat_s_o = res_o[15:0];
    end
    sat_u_o = (res_o > ALU_W'(65535)) ? 16'hffff : res_o[15:0];
  end

endmodule

### hdl/trge_fields.sv
// Picks report fields and the first two active contacts out of the byte
// stream read back from the report store. Depends on trge_pkg.
module trge_fields
  import trge_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              vld_i,
  input  logic [WIDX_W-1:0] idx_i,
  input  logic [7:0]        data_i,
  output fields_t           fields_o
);

  fields_t    f_q;
  logic [2:0] ph_q;
  logic       cap_q;
  logic       slot_q;

  assign fields_o = f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q    <= '0;
      ph_q   <= '0;
      cap_q  <= 1'b0;
      slot_q <= 1'b0;
    end else if (start_i) begin
      f_q.active <= '0;
      ph_q       <= '0;
      cap_q      <= 1'b0;
    end else if (vld_i) begin
      case (int'(idx_i))
        OFS_LEN_LO:  f_q.len[7:0]  <= data_i;
        OFS_LEN_HI:  f_q.len[15:8] <= data_i;
        OFS_RID:     f_q.rid       <= data_i;
        OFS_BUTTONS: f_q.buttons   <= data_i;
        OFS_DX:      f_q.dx        <= data_i;
        OFS_DY:      f_q.dy        <= data_i;
        OFS_COUNT:   f_q.count     <= data_i;
        OFS_CLICK:   f_q.click     <= data_i;
        default: ;
      endcase
      if (int'(idx_i) >= CONTACT_BASE && int'(idx_i) <= CONTACT_END) begin
        ph_q <= (ph_q == 3'(CONTACT_STRIDE - 1)) ? 3'd0 : ph_q + 3'd1;
        case (ph_q)
          3'd0: begin
            // flags byte: bit 1 marks a finger on the pad
            if (data_i[1]) begin
              cap_q  <= (f_q.active != 2'd2);
              slot_q <= f_q.active[0];
              if (f_q.active == 2'd0) begin
                f_q.id0 <= data_i[4:2];
              end
              if (f_q.active != 2'd2) begin
                f_q.active <= f_q.active + 2'd1;
              end
            end else begin
              cap_q <= 1'b0;
            end
          end
          3'd1: if (cap_q) begin
            if (slot_q) f_q.x1[7:0] <= data_i;
            else        f_q.x0[7:0] <= data_i;
          end
          3'd2: if (cap_q) begin
            if (slot_q) f_q.x1[15:8] <= data_i;
            else        f_q.x0[15:8] <= data_i;
          end
          3'd3: if (cap_q) begin
            if (slot_q) f_q.y1[7:0] <= data_i;
            else        f_q.y0[7:0] <= data_i;
          end
          3'd4: if (cap_q) begin
            if (slot_q) f_q.y1[15:8] <= data_i;
            else        f_q.y0[15:8] <= data_i;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

### hdl/trge_edgeq.sv
// Button state and button-edge queue; drops new edges when full.
// Depends on trge_pkg.
module trge_edgeq
  import trge_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [1:0]  push_val_i,
  input  logic        pop_i,
  output logic        head_vld_o,
  output logic [1:0]  head_val_o,
  output logic [1:0]  buttons_o,
  output logic [31:0] drop_cnt_o
);

  logic [1:0]      q_q [EDGE_DEPTH];
  logic [EQ_W-1:0] head_q, tail_q, head_nx, tail_nx;
  logic [1:0]      btn_q;
  logic [31:0]     drop_q;

  assign head_nx    = (head_q == EQ_W'(EDGE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_nx    = (tail_q == EQ_W'(EDGE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign head_vld_o = (head_q != tail_q);
  assign head_val_o = head_vld_o ? q_q[tail_q] : 2'd0;
  assign buttons_o  = btn_q;
  assign drop_cnt_o = drop_q;

  always_ff @(posedge clk_i) begin
    if (push_i && push_val_i != btn_q && head_nx != tail_q) begin
      q_q[head_q] <= push_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      btn_q  <= '0;
      drop_q <= '0;
    end else begin
      if (push_i && push_val_i != btn_q) begin
        btn_q <= push_val_i;
        if (head_nx == tail_q) begin
          drop_q <= drop_q + 32'd1;
        end else begin
          head_q <= head_nx;
        end
      end
      if (pop_i && head_vld_o) begin
        tail_q <= tail_nx;
      end
    end
  end

endmodule

### hdl/touchpad_report_gesture_engine_top.sv
// Top level of the touchpad report gesture engine: byte intake, report
// sequencer, gesture state and result beat. Depends on trge_pkg,
// trge_ram, trge_alu, trge_fields and trge_edgeq.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+---------------------------
//   in      | sink      | in_valid_i / in_stall_o      | op, data_byte, last_byte,
//           |           |                              | tick_time
//   out     | source    | out_valid_o / out_stall_i    | kind ... edge_drop_count
//   cfg     | sink      | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
// A last byte starts a walk over all 32 bytes of the report store (one RAM
// read port, one byte a cycle), then a decode on the shared adder; a
// two-finger scroll runs the bit-serial divider. in_stall_o is high while
// the sequencer runs or a result beat waits and is stalled. Reset is
// asynchronous and clears all control state; the store needs no clearing.
module touchpad_report_gesture_engine_top
  import trge_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] tick_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic        accepted_o,
  output logic signed [15:0] motion_x_o,
  output logic signed [15:0] motion_y_o,
  output logic signed [15:0] wheel_steps_o,
  output logic        edge_valid_o,
  output logic [1:0]  edge_buttons_o,
  output logic [31:0] report_count_o,
  output logic [31:0] malformed_count_o,
  output logic [31:0] edge_drop_count_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_WALK, ST_DRAIN, ST_DECIDE,
    ST_M_X, ST_M_Y, ST_M_BTN,
    ST_L_DT, ST_L_P1, ST_L_P0,
    ST_S_CY, ST_S_D, ST_S_T, ST_S_ABS, ST_S_DIV, ST_S_W, ST_S_R,
    ST_P_DX, ST_P_DY, ST_P_SX, ST_P_SY, ST_P_TX, ST_P_TY, ST_P_NEW,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_POINT  = 2'd1,
    MODE_SCROLL = 2'd2
  } gesture_e;

  state_e   state_q;
  gesture_e mode_q;

  // configuration
  logic [7:0]  scroll_step_q;
  logic [15:0] tap_time_q, tap_travel_q;

  // report intake
  logic [15:0] byte_cnt_q;
  logic [31:0] ticks_q;
  logic [WIDX_W-1:0] walk_q, rd_idx_q;
  logic        rd_vld_q;
  logic        ok_q;

  // gesture state
  logic        fv_q, tap_pend_q;
  logic [2:0]  fid_q;
  logic [15:0] last_x_q, last_y_q, anchor_q, tap_dist_q, cy_q;
  logic [31:0] tap_start_q;
  logic signed [15:0] rem_q, sum_x_q, sum_y_q, sum_w_q;
  logic [31:0] acc_q, rej_q;

  // scratch for the decode steps
  logic signed [17:0] delta_q, tot_q;
  logic signed [16:0] dx_q, dy_q;
  logic        neg_q;
  logic [MAG_W-1:0] mag_q, quo_q;
  logic [7:0]  part_q;
  logic [4:0]  div_cnt_q;

  // result beat
  logic        out_vld_q, kind_q, acc_out_q, ev_q;
  logic [1:0]  eb_q;
  logic [15:0] mx_q, my_q, mw_q;
  logic [31:0] rc_q, mc_q, dc_q;

  logic        in_acc, out_take, start_walk;
  logic [7:0]  rdata;
  fields_t     fld;
  logic        push, pop, head_vld;
  logic [1:0]  push_val, head_val, buttons;
  logic [31:0] drop_cnt;
  logic signed [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic        alu_sub;
  logic [15:0] sat_s, sat_u;
  logic [7:0]  step_eff;
  logic [8:0]  shifted;
  logic        hdr_ok, tracked, lift_tap;

  assign out_take   = out_vld_q && !out_stall_i;
  assign in_stall_o = !(state_q == ST_IDLE && (!out_vld_q || !out_stall_i));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start_walk = in_acc && !op_i && last_byte_i;
  assign pop        = in_acc && op_i;

  assign out_valid_o       = out_vld_q;
  assign kind_o            = kind_q;
  assign accepted_o        = acc_out_q;
  assign motion_x_o        = mx_q;
  assign motion_y_o        = my_q;
  assign wheel_steps_o     = mw_q;
  assign edge_valid_o      = ev_q;
  assign edge_buttons_o    = eb_q;
  assign report_count_o    = rc_q;
  assign malformed_count_o = mc_q;
  assign edge_drop_count_o = dc_q;

  trge_ram #(.Width(8), .Depth(STORE_BYTES)) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && !op_i && byte_cnt_q < 16'(STORE_BYTES)),
    .waddr_i (byte_cnt_q[SA_W-1:0]),
    .wdata_i (data_byte_i),
    .raddr_i (SA_W'(walk_q)),
    .rdata_o (rdata)
  );

  trge_fields u_fields (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_walk),
    .vld_i    (rd_vld_q),
    .idx_i    (rd_idx_q),
    .data_i   (rdata),
    .fields_o (fld)
  );

  trge_edgeq u_edges (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_val_i (push_val),
    .pop_i      (pop),
    .head_vld_o (head_vld),
    .head_val_o (head_val),
    .buttons_o  (buttons),
    .drop_cnt_o (drop_cnt)
  );

  trge_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .sat_s_o (sat_s),
    .sat_u_o (sat_u)
  );

  assign step_eff = (scroll_step_q == 8'd0) ? 8'd1 : scroll_step_q;
  assign shifted  = {part_q, mag_q[MAG_W-1]};
  assign hdr_ok   = byte_cnt_q >= HDR_MIN_LEN && fld.len >= HDR_MIN_LEN &&
                    fld.len <= byte_cnt_q;
  assign tracked  = mode_q == MODE_POINT && fv_q && fid_q == fld.id0;
  assign lift_tap = tap_pend_q && alu_res[31:0] <= {16'd0, tap_time_q} &&
                    tap_dist_q <= tap_travel_q && buttons == 2'd0;

  // Operand select for the shared adder, one operation per step.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_M_X:   begin alu_a = ALU_W'(sum_x_q); alu_b = ALU_W'($signed(fld.dx)); end
      ST_M_Y:   begin alu_a = ALU_W'(sum_y_q); alu_b = ALU_W'($signed(fld.dy)); end
      ST_L_DT:  begin
        alu_a = ALU_W'(ticks_q); alu_b = ALU_W'(tap_start_q); alu_sub = 1'b1;
      end
      ST_S_CY:  begin alu_a = ALU_W'(fld.y0); alu_b = ALU_W'(fld.y1); end
      ST_S_D:   begin alu_a = ALU_W'(cy_q); alu_b = ALU_W'(anchor_q); alu_sub = 1'b1; end
      ST_S_T:   begin alu_a = ALU_W'(rem_q); alu_b = ALU_W'(delta_q); end
      ST_S_ABS: begin alu_b = ALU_W'(tot_q); alu_sub = neg_q; end
      ST_S_DIV: begin alu_a = ALU_W'(shifted); alu_b = ALU_W'(step_eff); alu_sub = 1'b1; end
      ST_S_W:   begin alu_a = ALU_W'(sum_w_q); alu_b = ALU_W'(quo_q); alu_sub = !neg_q; end
      ST_S_R:   begin alu_b = ALU_W'(part_q); alu_sub = neg_q; end
      ST_P_DX:  begin alu_a = ALU_W'(fld.x0); alu_b = ALU_W'(last_x_q); alu_sub = 1'b1; end
      ST_P_DY:  begin alu_a = ALU_W'(fld.y0); alu_b = ALU_W'(last_y_q); alu_sub = 1'b1; end
      ST_P_SX:  begin alu_a = ALU_W'(sum_x_q); alu_b = ALU_W'(dx_q); end
      ST_P_SY:  begin alu_a = ALU_W'(sum_y_q); alu_b = ALU_W'(dy_q); end
      ST_P_TX:  begin alu_a = ALU_W'(tap_dist_q); alu_b = ALU_W'(dx_q); alu_sub = dx_q[16]; end
      ST_P_TY:  begin alu_a = ALU_W'(tap_dist_q); alu_b = ALU_W'(dy_q); alu_sub = dy_q[16]; end
      default: ;
    endcase
  end

  // Button pushes: physical click at decode, mouse buttons, tap click pair.
  always_comb begin
    push     = 1'b0;
    push_val = 2'd0;
    case (state_q)
      ST_DECIDE: begin
        push     = hdr_ok && fld.rid == RID_PREC && fld.len >= PREC_MIN_LEN &&
                   fld.count[6:0] <= MAX_CONTACTS;
        push_val = {1'b0, fld.click[0]};
      end
      ST_M_BTN: begin push = 1'b1; push_val = fld.buttons[1:0]; end
      ST_L_P1:  begin push = 1'b1; push_val = 2'd1; end
      ST_L_P0:  begin push = 1'b1; push_val = 2'd0; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mode_q        <= MODE_IDLE;
      scroll_step_q <= 8'd24;
      tap_time_q    <= 16'd20;
      tap_travel_q  <= 16'd24;
      byte_cnt_q    <= '0;
      ticks_q       <= '0;
      walk_q        <= '0;
      rd_idx_q      <= '0;
      rd_vld_q      <= 1'b0;
      ok_q          <= 1'b0;
      fv_q          <= 1'b0;
      tap_pend_q    <= 1'b0;
      fid_q         <= '0;
      last_x_q      <= '0;
      last_y_q      <= '0;
      anchor_q      <= '0;
      tap_dist_q    <= '0;
      cy_q          <= '0;
      tap_start_q   <= '0;
      rem_q         <= '0;
      sum_x_q       <= '0;
      sum_y_q       <= '0;
      sum_w_q       <= '0;
      acc_q         <= '0;
      rej_q         <= '0;
      delta_q       <= '0;
      tot_q         <= '0;
      dx_q          <= '0;
      dy_q          <= '0;
      neg_q         <= 1'b0;
      mag_q         <= '0;
      quo_q         <= '0;
      part_q        <= '0;
      div_cnt_q     <= '0;
      out_vld_q     <= 1'b0;
      kind_q        <= 1'b0;
      acc_out_q     <= 1'b0;
      ev_q          <= 1'b0;
      eb_q          <= '0;
      mx_q          <= '0;
      my_q          <= '0;
      mw_q          <= '0;
      rc_q          <= '0;
      mc_q          <= '0;
      dc_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCROLL_STEP: scroll_step_q <= cfg_data_i[7:0];
          CFG_TAP_TIME:    tap_time_q    <= cfg_data_i;
          CFG_TAP_TRAVEL:  tap_travel_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_take) begin
        out_vld_q <= 1'b0;
      end
      rd_vld_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (in_acc && op_i) begin
            // take beat: return and clear the sums, pop one edge
            out_vld_q <= 1'b1;
            kind_q    <= 1'b1;
            acc_out_q <= 1'b0;
            mx_q      <= sum_x_q;
            my_q      <= sum_y_q;
            mw_q      <= sum_w_q;
            ev_q      <= head_vld;
            eb_q      <= head_val;
            rc_q      <= acc_q;
            mc_q      <= rej_q;
            dc_q      <= drop_cnt;
            sum_x_q   <= '0;
            sum_y_q   <= '0;
            sum_w_q   <= '0;
          end else if (in_acc) begin
            if (byte_cnt_q != 16'hffff) begin
              byte_cnt_q <= byte_cnt_q + 16'd1;
            end
            if (last_byte_i) begin
              ticks_q <= tick_time_i;
              walk_q  <= '0;
              state_q <= ST_WALK;
            end
          end
        end

        ST_WALK: begin
          rd_vld_q <= 1'b1;
          rd_idx_q <= walk_q;
          walk_q   <= walk_q + 1'b1;
          if (walk_q == WIDX_W'(PREC_LEN - 1)) begin
            state_q <= ST_DRAIN;
          end
        end

        ST_DRAIN: state_q <= ST_DECIDE;

        ST_DECIDE: begin
          ok_q    <= 1'b0;
          state_q <= ST_FIN;
          if (hdr_ok && fld.rid == RID_MOUSE) begin
            if (fld.len >= MOUSE_MIN_LEN) begin
              ok_q       <= 1'b1;
              mode_q     <= MODE_IDLE;
              fv_q       <= 1'b0;
              tap_pend_q <= 1'b0;
              state_q    <= ST_M_X;
            end
          end else if (hdr_ok && fld.rid == RID_PREC) begin
            if (push) begin
              ok_q <= 1'b1;
              if (fld.click[0]) begin
                tap_pend_q <= 1'b0;
              end
              if (fld.active == 2'd0) begin
                state_q <= ST_L_DT;
              end else if (fld.active == 2'd2) begin
                state_q <= ST_S_CY;
              end else if (tracked) begin
                state_q <= ST_P_DX;
              end else begin
                state_q <= ST_P_NEW;
              end
            end
          end
        end

        // mouse report
        ST_M_X: begin sum_x_q <= sat_s; state_q <= ST_M_Y; end
        ST_M_Y: begin sum_y_q <= sat_s; state_q <= ST_M_BTN; end
        ST_M_BTN: state_q <= ST_FIN;

        // all fingers lifted
        ST_L_DT: begin
          if (lift_tap) begin
            state_q <= ST_L_P1;
          end else begin
            mode_q     <= MODE_IDLE;
            fv_q       <= 1'b0;
            tap_pend_q <= 1'b0;
            rem_q      <= '0;
            state_q    <= ST_FIN;
          end
        end
        ST_L_P1: state_q <= ST_L_P0;
        ST_L_P0: begin
          mode_q     <= MODE_IDLE;
          fv_q       <= 1'b0;
          tap_pend_q <= 1'b0;
          rem_q      <= '0;
          state_q    <= ST_FIN;
        end

        // two fingers: wheel steps from centroid travel
        ST_S_CY: begin
          tap_pend_q <= 1'b0;
          if (mode_q == MODE_SCROLL) begin
            cy_q    <= alu_res[16:1];
            state_q <= ST_S_D;
          end else begin
            rem_q    <= '0;
            mode_q   <= MODE_SCROLL;
            anchor_q <= alu_res[16:1];
            fv_q     <= 1'b0;
            state_q  <= ST_FIN;
          end
        end
        ST_S_D: begin delta_q <= alu_res[17:0]; state_q <= ST_S_T; end
        ST_S_T: begin
          tot_q   <= alu_res[17:0];
          neg_q   <= alu_res[ALU_W-1];
          state_q <= ST_S_ABS;
        end
        ST_S_ABS: begin
          mag_q     <= alu_res[MAG_W-1:0];
          part_q    <= '0;
          quo_q     <= '0;
          div_cnt_q <= '0;
          state_q   <= ST_S_DIV;
        end
        ST_S_DIV: begin
          // one quotient bit per cycle, restoring
          if (!alu_res[ALU_W-1]) begin
            part_q <= alu_res[7:0];
            quo_q  <= {quo_q[MAG_W-2:0], 1'b1};
          end else begin
            part_q <= shifted[7:0];
            quo_q  <= {quo_q[MAG_W-2:0], 1'b0};
          end
          mag_q     <= {mag_q[MAG_W-2:0], 1'b0};
          div_cnt_q <= div_cnt_q + 5'd1;
          if (div_cnt_q == 5'(MAG_W - 1)) begin
            state_q <= ST_S_W;
          end
        end
        ST_S_W: begin sum_w_q <= sat_s; state_q <= ST_S_R; end
        ST_S_R: begin
          rem_q    <= alu_res[15:0];
          mode_q   <= MODE_SCROLL;
          anchor_q <= cy_q;
          fv_q     <= 1'b0;
          state_q  <= ST_FIN;
        end

        // one finger: pointer motion and tap travel
        ST_P_DX: begin dx_q <= alu_res[16:0]; state_q <= ST_P_DY; end
        ST_P_DY: begin dy_q <= alu_res[16:0]; state_q <= ST_P_SX; end
        ST_P_SX: begin sum_x_q <= sat_s; state_q <= ST_P_SY; end
        ST_P_SY: begin sum_y_q <= sat_s; state_q <= ST_P_TX; end
        ST_P_TX: begin tap_dist_q <= sat_u; state_q <= ST_P_TY; end
        ST_P_TY, ST_P_NEW: begin
          if (state_q == ST_P_TY) begin
            tap_dist_q <= sat_u;
          end else begin
            tap_pend_q  <= !fld.click[0];
            tap_start_q <= ticks_q;
            tap_dist_q  <= '0;
          end
          mode_q   <= MODE_POINT;
          fv_q     <= 1'b1;
          fid_q    <= fld.id0;
          last_x_q <= fld.x0;
          last_y_q <= fld.y0;
          state_q  <= ST_FIN;
        end

        ST_FIN: begin
          // verdict beat; the output register is free since the last byte
          out_vld_q  <= 1'b1;
          kind_q     <= 1'b0;
          acc_out_q  <= ok_q;
          mx_q       <= '0;
          my_q       <= '0;
          mw_q       <= '0;
          ev_q       <= 1'b0;
          eb_q       <= '0;
          rc_q       <= acc_q + {31'd0, ok_q};
          mc_q       <= rej_q + {31'd0, !ok_q};
          dc_q       <= drop_cnt;
          acc_q      <= acc_q + {31'd0, ok_q};
          rej_q      <= rej_q + {31'd0, !ok_q};
          byte_cnt_q <= '0;
          state_q    <= ST_IDLE;
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
